>>> hw/rtl/rau_pkg.sv
// package for the rational arithmetic unit: widths, action codes, sequencer states
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int ACTION_WIDTH = 3;

    localparam logic [ACTION_WIDTH-1:0] ACT_ADD = 3'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_SUB = 3'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_MUL = 3'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_DIV = 3'd3;
    localparam logic [ACTION_WIDTH-1:0] ACT_INC = 3'd4;
    localparam logic [ACTION_WIDTH-1:0] ACT_DEC = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FORM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } rau_state_t;
endpackage
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: sequencer, shared multiplier, gcd, divider
// sequence: multiply states ST_MUL0, ST_MUL1 and ST_MUL2, a form state, the binary gcd loop,
//   then two restoring divisions on the shared divider, numerator first and then denominator
// throughput: one item at a time; s_ready is high only in idle, after the result transfer
// the binary gcd loop and the one shared divider set the item time
// reset: aresetn synchronous active low, returns the sequencer to idle with no result held
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ACTION_WIDTH-1:0]    s_action,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_first_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_first_denominator,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_second_numerator,
    input  wire logic signed [OPERAND_WIDTH-1:0] s_second_denominator,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [2*OPERAND_WIDTH:0] m_result_numerator,
    output logic signed [2*OPERAND_WIDTH:0] m_result_denominator,
    output logic                            m_zero_over_zero
);
    localparam int OW = OPERAND_WIDTH;
    localparam int RW = 2 * OPERAND_WIDTH + 1;
    localparam int SW = $clog2(RW + 1);

    rau_state_t state_reg, state_next;

    // captured operands
    logic [ACTION_WIDTH-1:0] act_reg, act_next;
    logic signed [OW-1:0] n1_reg, n1_next, d1_reg, d1_next;
    logic signed [OW-1:0] n2_reg, n2_next, d2_reg, d2_next;

    // products from the shared multiplier
    logic signed [RW-1:0] p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic signed [RW-1:0] num_reg, num_next, den_reg, den_next;

    // gcd working values
    logic [RW-1:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [SW-1:0] sh_reg, sh_next;

    logic [RW-1:0] qn_reg, qn_next;
    logic          zoz_reg, zoz_next;
    logic signed [RW-1:0] rn_reg, rn_next, rd_reg, rd_next;

    // one signed multiplier shared over the three multiply states, full product then sign extended
    logic signed [OW-1:0]   ma, mb;
    logic signed [2*OW-1:0] mfull;
    logic signed [RW-1:0]   mprod;
    assign mfull = ma * mb;
    assign mprod = RW'(mfull);

    logic [RW-1:0] num_mag, den_mag, gdiff;
    assign num_mag = num_reg[RW-1] ? RW'(-num_reg) : RW'(num_reg);
    assign den_mag = den_reg[RW-1] ? RW'(-den_reg) : RW'(den_reg);
    assign gdiff   = (ga_reg > gb_reg) ? ga_reg - gb_reg : gb_reg - ga_reg;

    // divider shared for numerator and denominator
    logic          div_start, div_done;
    logic [RW-1:0] div_dividend, div_divisor, div_q;

    rau_divider #(.W(RW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // one of the two working values is zero at the hand-off, so a|b is the odd part
    assign div_divisor = (ga_reg | gb_reg) << sh_reg;

    always_comb begin
        state_next = state_reg;
        act_next = act_reg;
        n1_next = n1_reg; d1_next = d1_reg; n2_next = n2_reg; d2_next = d2_reg;
        p0_next = p0_reg; p1_next = p1_reg; p2_next = p2_reg;
        num_next = num_reg; den_next = den_reg;
        ga_next = ga_reg; gb_next = gb_reg; sh_next = sh_reg;
        qn_next = qn_reg; zoz_next = zoz_reg; rn_next = rn_reg; rd_next = rd_reg;
        ma = n1_reg; mb = d2_reg;
        div_start = 1'b0;
        div_dividend = num_mag;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next = s_action;
                    n1_next = s_first_numerator;  d1_next = s_first_denominator;
                    n2_next = s_second_numerator; d2_next = s_second_denominator;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                // n1*d2, or n1*n2 for multiply
                ma = n1_reg;
                mb = (act_reg == ACT_MUL) ? n2_reg : d2_reg;
                p0_next = mprod;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                // n2*d1, or d1*n2 for divide
                ma = n2_reg; mb = d1_reg;
                p1_next = mprod;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                ma = d1_reg; mb = d2_reg;
                p2_next = mprod;
                state_next = ST_FORM;
            end
            ST_FORM: begin
                zoz_next = 1'b0;
                state_next = ST_GCD;
                case (act_reg)
                    ACT_ADD: begin num_next = p0_reg + p1_reg; den_next = p2_reg; end
                    ACT_SUB: begin num_next = p0_reg - p1_reg; den_next = p2_reg; end
                    ACT_MUL: begin num_next = p0_reg; den_next = p2_reg; end
                    ACT_DIV: begin num_next = p0_reg; den_next = p1_reg; end
                    ACT_INC: begin
                        num_next = RW'(n1_reg) + RW'(d1_reg); den_next = RW'(d1_reg);
                    end
                    ACT_DEC: begin
                        num_next = RW'(n1_reg) - RW'(d1_reg); den_next = RW'(d1_reg);
                    end
                    default: begin
                        // undefined action gives all zero fields
                        rn_next = '0; rd_next = '0;
                        state_next = ST_OUT;
                    end
                endcase
                sh_next = '0;
                ga_next = '0; gb_next = '0;
            end
            ST_GCD: begin
                // first pass loads magnitudes, marked by both working values zero
                if (ga_reg == '0 && gb_reg == '0 && sh_reg == '0 &&
                    (num_mag != '0 || den_mag != '0) && !zoz_reg) begin
                    ga_next = num_mag; gb_next = den_mag;
                    zoz_next = 1'b1; // reused as loaded flag during gcd
                end else if (!zoz_reg) begin
                    // both values zero
                    rn_next = '0; rd_next = '0; zoz_next = 1'b1;
                    state_next = ST_OUT;
                end else if (ga_reg == '0 || gb_reg == '0) begin
                    // gcd = (a|b) << sh, a|b kept in ga
                    ga_next = ga_reg | gb_reg;
                    zoz_next = 1'b0;
                    div_start = 1'b1;
                    state_next = ST_DIVN;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1; gb_next = gb_reg >> 1;
                    sh_next = sh_reg + 1'b1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else begin
                    ga_next = gdiff;
                    gb_next = (ga_reg < gb_reg) ? ga_reg : gb_reg;
                end
            end
            ST_DIVN: begin
                // numerator division started on the gcd hand-off
                div_dividend = num_mag;
                if (div_done) begin
                    qn_next = div_q;
                    state_next = ST_DIVD;
                    div_start = 1'b1;
                    div_dividend = den_mag;
                end
            end
            ST_DIVD: begin
                div_dividend = den_mag;
                if (div_done) begin
                    rn_next = num_reg[RW-1] ? RW'(-qn_reg) : RW'(qn_reg);
                    rd_next = den_reg[RW-1] ? RW'(-div_q) : RW'(div_q);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        act_reg <= act_next;
        n1_reg <= n1_next; d1_reg <= d1_next; n2_reg <= n2_next; d2_reg <= d2_next;
        p0_reg <= p0_next; p1_reg <= p1_next; p2_reg <= p2_next;
        num_reg <= num_next; den_reg <= den_next;
        ga_reg <= ga_next; gb_reg <= gb_next; sh_reg <= sh_next;
        qn_reg <= qn_next; zoz_reg <= zoz_next; rn_reg <= rn_next; rd_reg <= rd_next;
    end

    assign m_result_numerator   = rn_reg;
    assign m_result_denominator = rd_reg;
    assign m_zero_over_zero     = zoz_reg & (state_reg == ST_OUT);
endmodule
`default_nettype wire

>>> hw/rtl/rau_divider.sv
// restoring divider, one quotient bit per cycle, unsigned
`default_nettype none
module rau_divider
    import rau_pkg::*;
#(
    parameter int W = 33
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[W]) begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end else begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

>>> hw/rtl/rau_checker.sv
// port-level checker for the rational arithmetic unit, bound to the top level
`default_nettype none
module rau_checker
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_valid,
    input wire logic                     s_ready,
    input wire logic                     m_valid,
    input wire logic                     m_ready,
    input wire logic [2*OPERAND_WIDTH:0] m_result_numerator,
    input wire logic [2*OPERAND_WIDTH:0] m_result_denominator,
    input wire logic                     m_zero_over_zero
);
    // no input taken while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    // a transfer in never yields a result on the next edge
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_numerator)
            && $stable(m_result_denominator))) else $error("result dropped");
    // zero over zero gives zero fields
    a_zoz: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_over_zero) |-> (m_result_numerator == '0
            && m_result_denominator == '0)) else $error("bad zero over zero");
endmodule

bind rational_arithmetic_unit rau_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_result_numerator(m_result_numerator),
    .m_result_denominator(m_result_denominator), .m_zero_over_zero(m_zero_over_zero)
);
`default_nettype wire

>>> dv/rau_scoreboard.sv
// scoreboard class: predicts reduced fractions and checks result transfers
class rau_scoreboard;
    typedef struct {
        logic signed [32:0] num;
        logic signed [32:0] den;
        logic               zoz;
    } fraction_t;

    fraction_t pending_fractions[$];
    int        error_count;

    function new();
        error_count = 0;
    endfunction

    static function longint unsigned mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function void note_input(logic [2:0] act, logic signed [15:0] n1, logic signed [15:0] d1,
                             logic signed [15:0] n2, logic signed [15:0] d2);
        fraction_t f;
        longint num, den;
        longint unsigned a, b, t;
        f.num = '0;
        f.den = '0;
        f.zoz = 1'b0;
        num = 0;
        den = 0;
        case (act)
            rau_pkg::ACT_ADD: begin
                num = longint'(n1) * d2 + longint'(n2) * d1;
                den = longint'(d1) * d2;
            end
            rau_pkg::ACT_SUB: begin
                num = longint'(n1) * d2 - longint'(n2) * d1;
                den = longint'(d1) * d2;
            end
            rau_pkg::ACT_MUL: begin
                num = longint'(n1) * n2;
                den = longint'(d1) * d2;
            end
            rau_pkg::ACT_DIV: begin
                num = longint'(n1) * d2;
                den = longint'(d1) * n2;
            end
            rau_pkg::ACT_INC: begin
                num = longint'(n1) + d1;
                den = d1;
            end
            rau_pkg::ACT_DEC: begin
                num = longint'(n1) - d1;
                den = d1;
            end
            default: begin
                pending_fractions.push_back(f);
                return;
            end
        endcase
        a = mag(num);
        b = mag(den);
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        if (a == 0) begin
            f.zoz = 1'b1;
        end else begin
            f.num = num / longint'(a);
            f.den = den / longint'(a);
        end
        pending_fractions.push_back(f);
    endfunction

    function void check_result(logic signed [32:0] num, logic signed [32:0] den, logic zoz);
        fraction_t f;
        if (pending_fractions.size() == 0) begin
            $display("%0t: unexpected result %0d/%0d zoz %0b", $time, num, den, zoz);
            error_count++;
            return;
        end
        f = pending_fractions.pop_front();
        if (num !== f.num) begin
            $display("%0t: numerator expected %0d actual %0d", $time, f.num, num);
            error_count++;
        end
        if (den !== f.den) begin
            $display("%0t: denominator expected %0d actual %0d", $time, f.den, den);
            error_count++;
        end
        if (zoz !== f.zoz) begin
            $display("%0t: zero_over_zero expected %0b actual %0b", $time, f.zoz, zoz);
            error_count++;
        end
    endfunction
endclass

>>> dv/tb_top.sv
// testbench top: drives rational_arithmetic_unit and checks every result transfer
module tb_top;
    import rau_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_action;
    logic signed [15:0] s_first_numerator;
    logic signed [15:0] s_first_denominator;
    logic signed [15:0] s_second_numerator;
    logic signed [15:0] s_second_denominator;
    logic m_valid;
    logic m_ready;
    logic signed [32:0] m_result_numerator;
    logic signed [32:0] m_result_denominator;
    logic m_zero_over_zero;

    rau_scoreboard fraction_board;
    bit  stimulus_done;
    bit  hold_off;
    longint cycle_count;

    rational_arithmetic_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_first_numerator(s_first_numerator), .s_first_denominator(s_first_denominator),
        .s_second_numerator(s_second_numerator), .s_second_denominator(s_second_denominator),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_numerator(m_result_numerator), .m_result_denominator(m_result_denominator),
        .m_zero_over_zero(m_zero_over_zero)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // pick an operand value, biased toward extremes and small magnitudes
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // present one item and hold it until the transfer happens
    task automatic send_fraction_pair(logic [2:0] act, logic [15:0] n1, logic [15:0] d1,
                                      logic [15:0] n2, logic [15:0] d2);
        s_valid <= 1'b1;
        s_action <= act;
        s_first_numerator <= n1;
        s_first_denominator <= d1;
        s_second_numerator <= n2;
        s_second_denominator <= d2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fraction_board.note_input(act, n1, d1, n2, d2);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // cycle limit: a generous bound for the 600+ items plus stalls
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sample result transfers at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            fraction_board.check_result(m_result_numerator, m_result_denominator,
                                        m_zero_over_zero);
    end

    // receiver: random stall pattern, with a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off)
                m_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // long hold-off, counted in its own process, while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        wait (fraction_board != null && aresetn);
        repeat (2000) @(negedge aclk);
        hold_off = 1'b1;
        repeat (1500) @(negedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        int burst;
        logic [15:0] edge_vals [4];
        fraction_board = new();
        cycle_count = 0;
        stimulus_done = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = '0;
        s_first_numerator = '0;
        s_first_denominator = '0;
        s_second_numerator = '0;
        s_second_denominator = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every action on extreme operands
        edge_vals = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001};
        for (int a = 0; a < 6; a++)
            send_fraction_pair(3'(a), edge_vals[a % 4], edge_vals[(a + 1) % 4],
                               edge_vals[(a + 2) % 4], edge_vals[(a + 3) % 4]);
        send_fraction_pair(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction_pair(ACT_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_fraction_pair(ACT_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        // both values zero
        send_fraction_pair(ACT_ADD, 16'h0000, 16'h0000, 16'h0005, 16'h0000);
        send_fraction_pair(ACT_MUL, 16'h0003, 16'h0000, 16'h0000, 16'h0007);
        send_fraction_pair(ACT_INC, 16'h0000, 16'h0000, 16'h1234, 16'h4321);
        // zero numerator with nonzero denominator, both signs
        send_fraction_pair(ACT_SUB, 16'h0004, 16'h0006, 16'h0004, 16'h0006);
        send_fraction_pair(ACT_DEC, 16'hfffb, 16'hfffb, 16'h0000, 16'h0000);
        send_fraction_pair(ACT_MUL, 16'h0000, 16'hfffd, 16'h0009, 16'h0002);
        // divide by zero second numerator, negative denominators
        send_fraction_pair(ACT_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0005);
        send_fraction_pair(ACT_DIV, 16'h0006, 16'hfff8, 16'h0009, 16'hfffa);
        send_fraction_pair(ACT_INC, 16'h0002, 16'hfffd, 16'h0000, 16'h0000);
        // undefined actions
        send_fraction_pair(3'd6, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
        send_fraction_pair(3'd7, 16'hffff, 16'h8000, 16'h7fff, 16'h0000);

        // random bursts with gaps
        for (int i = 0; i < 600; i += burst) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++)
                send_fraction_pair(($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                                : 3'($urandom_range(0, 5)),
                                   pick_operand(), pick_operand(),
                                   pick_operand(), pick_operand());
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 200));
        end
        s_valid <= 1'b0;
        stimulus_done = 1'b1;

        while (fraction_board.pending_fractions.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fraction_board.error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
